// ===== hw/rtl/kmp_pkg.sv =====
package kmp_pkg;

    localparam int PAT_MAX   = 64;
    localparam int IDX_W     = $clog2(PAT_MAX);
    localparam int CNT_W     = IDX_W + 1;
    localparam int POS_WIDTH = 32;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_DROPPED   = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       begin_flag;
    } t_in_item;

    typedef struct packed {
        logic                 match_found;
        logic [POS_WIDTH-1:0] match_start;
        logic [1:0]           status_code;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT_LINK,
        ST_PAT_CMP,
        ST_TXT_CMP,
        ST_TXT_LINK
    } t_state;

endpackage

// ===== hw/rtl/kmp_stream_matcher.sv =====
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
// output  | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// One item at a time. A first or dropped pattern byte is done in idle; other pattern
// bytes fetch the previous failure link, then compare, following a link per failed
// compare. A text byte is done in idle with an empty pattern, else compares likewise and
// fetches a link on a match, serially: one compare unit, one read port per memory.
// Reset (synchronous, active low) clears counts, matched length, position and control;
// the pattern and failure memories are not cleared. The next transfer is taken only
// when the sequencer is idle and the output register is free or being emptied.
module kmp_stream_matcher
    import kmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    logic [7:0]       pat_mem  [PAT_MAX];
    logic [IDX_W-1:0] fail_mem [PAT_MAX];

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_matched, n_matched;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [7:0]           r_char, n_char;
    logic [1:0]           r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_data, n_out_data;

    logic [7:0]       r_pat_rd;
    logic [IDX_W-1:0] r_fail_rd;

    logic [IDX_W-1:0] pat_addr;
    logic [IDX_W-1:0] fail_addr;
    logic             pat_we;
    logic [IDX_W-1:0] pat_waddr;
    logic             fail_we;
    logic [IDX_W-1:0] fail_waddr;
    logic [IDX_W-1:0] fail_wdata;

    logic             in_take;
    logic             out_load;
    logic [CNT_W-1:0] cnt0;
    logic [CNT_W-1:0] matched0;
    logic [CNT_W-1:0] k_start;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W-1:0] k_link;
    logic [POS_WIDTH-1:0] pos0;

    assign o_in_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign k_inc  = r_k + CNT_W'(1);
    assign k_link = CNT_W'(r_fail_rd);

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[pat_waddr] <= i_in_data.byte_value;
        end
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        r_pat_rd  <= pat_mem[pat_addr];
        r_fail_rd <= fail_mem[fail_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_matched   <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_matched   <= n_matched;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_char     <= n_char;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_matched  = r_matched;
        n_k        = r_k;
        n_pos      = r_pos;
        n_char     = r_char;
        n_status   = r_status;
        n_out_data = r_out_data;
        out_load   = 1'b0;
        pat_addr   = r_k[IDX_W-1:0];
        fail_addr  = r_k[IDX_W-1:0] - IDX_W'(1);
        pat_we     = 1'b0;
        pat_waddr  = r_count[IDX_W-1:0];
        fail_we    = 1'b0;
        fail_waddr = r_count[IDX_W-1:0];
        fail_wdata = '0;

        cnt0     = i_in_data.begin_flag ? '0 : r_count;
        pos0     = i_in_data.begin_flag ? '0 : r_pos;
        matched0 = i_in_data.begin_flag ? '0 : r_matched;
        k_start  = (matched0 >= r_count) ? '0 : matched0;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_char = i_in_data.byte_value;
                    if (i_in_data.kind == KIND_PATTERN) begin
                        n_matched = '0;
                        n_count   = cnt0;
                        if (cnt0 == CNT_W'(PAT_MAX)) begin
                            out_load   = 1'b1;
                            n_out_data = '{match_found: 1'b0, match_start: '0,
                                           status_code: STATUS_DROPPED};
                        end else begin
                            pat_we    = 1'b1;
                            pat_waddr = cnt0[IDX_W-1:0];
                            if (cnt0 == '0) begin
                                fail_we    = 1'b1;
                                fail_waddr = '0;
                                fail_wdata = '0;
                                n_count    = CNT_W'(1);
                                out_load   = 1'b1;
                                n_out_data = '{match_found: 1'b0, match_start: '0,
                                               status_code: STATUS_OK};
                            end else begin
                                fail_addr = cnt0[IDX_W-1:0] - IDX_W'(1);
                                n_state   = ST_PAT_LINK;
                            end
                        end
                    end else begin
                        if (pos0 == POS_MAX) begin
                            n_pos    = POS_MAX;
                            n_status = STATUS_SATURATED;
                        end else begin
                            n_pos    = pos0 + POS_WIDTH'(1);
                            n_status = STATUS_OK;
                        end
                        if (r_count == '0) begin
                            n_matched  = '0;
                            out_load   = 1'b1;
                            n_out_data = '{match_found: 1'b0, match_start: '0,
                                           status_code: n_status};
                        end else begin
                            n_k       = k_start;
                            pat_addr  = k_start[IDX_W-1:0];
                            fail_addr = k_start[IDX_W-1:0] - IDX_W'(1);
                            n_state   = ST_TXT_CMP;
                        end
                    end
                end
            end

            ST_PAT_LINK: begin
                // Start the search from the failure length of the previous byte.
                n_k       = k_link;
                pat_addr  = r_fail_rd;
                fail_addr = r_fail_rd - IDX_W'(1);
                n_state   = ST_PAT_CMP;
            end

            ST_PAT_CMP: begin
                if (r_pat_rd == r_char || r_k == '0) begin
                    fail_we    = 1'b1;
                    fail_waddr = r_count[IDX_W-1:0];
                    fail_wdata = (r_pat_rd == r_char) ? k_inc[IDX_W-1:0] : '0;
                    n_count    = r_count + CNT_W'(1);
                    out_load   = 1'b1;
                    n_out_data = '{match_found: 1'b0, match_start: '0,
                                   status_code: STATUS_OK};
                    n_state    = ST_IDLE;
                end else begin
                    n_k       = k_link;
                    pat_addr  = r_fail_rd;
                    fail_addr = r_fail_rd - IDX_W'(1);
                end
            end

            ST_TXT_CMP: begin
                if (r_pat_rd == r_char) begin
                    if (k_inc == r_count) begin
                        // Full occurrence: fetch the failure entry of the last byte.
                        fail_addr = r_count[IDX_W-1:0] - IDX_W'(1);
                        n_state   = ST_TXT_LINK;
                    end else begin
                        n_matched  = k_inc;
                        out_load   = 1'b1;
                        n_out_data = '{match_found: 1'b0, match_start: '0,
                                       status_code: r_status};
                        n_state    = ST_IDLE;
                    end
                end else if (r_k == '0) begin
                    n_matched  = '0;
                    out_load   = 1'b1;
                    n_out_data = '{match_found: 1'b0, match_start: '0,
                                   status_code: r_status};
                    n_state    = ST_IDLE;
                end else begin
                    n_k       = k_link;
                    pat_addr  = r_fail_rd;
                    fail_addr = r_fail_rd - IDX_W'(1);
                end
            end

            ST_TXT_LINK: begin
                n_matched  = k_link;
                out_load   = 1'b1;
                n_out_data = '{match_found: 1'b1,
                               match_start: r_pos - POS_WIDTH'(r_count) + POS_WIDTH'(1),
                               status_code: r_status};
                n_state    = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PAT_MAX))
        else $error("pattern count beyond capacity");

    a_matched_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched == '0 || r_matched < r_count)
        else $error("matched length not below pattern count");

    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !r_out_valid)
        else $error("output register occupied while an item is in progress");

    a_text_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TXT_CMP |-> r_k < r_count)
        else $error("search index outside the stored pattern");

    a_match_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.match_found |->
            o_out_data.status_code != STATUS_DROPPED)
        else $error("match reported with a dropped-byte status");
`endif

endmodule
